// ----- rtl/core/torus_point_zbuffer_plot_assert.svh -----
// Assertion macros for the torus point plotter.
`ifndef TORUS_POINT_ZBUFFER_PLOT_ASSERT_SVH
`define TORUS_POINT_ZBUFFER_PLOT_ASSERT_SVH
`ifndef SYNTHESIS
`define TPZ_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) expr) \
    else $error("tpz check failed");
`define TPZ_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) expr) \
    else $error("tpz check failed");
`else
`define TPZ_ASSERT(label, expr)
`define TPZ_ASSERT_ALWAYS(label, expr)
`endif
`endif

// ----- rtl/core/tpz_pkg.sv -----
package tpz_pkg;

  localparam int COLS      = 80;
  localparam int ROWS      = 22;
  localparam int CELLS     = COLS * ROWS;
  localparam int ADDR_W    = 11;
  localparam int X_W       = $clog2(COLS);
  localparam int Y_W       = $clog2(ROWS);
  localparam int TMP_W     = 25;
  localparam int DIV_STEPS = 31;
  localparam int REM_W     = 22;
  localparam int CNT_W     = 11;
  localparam logic [3:0] BLANK = 4'd12;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_PLOT  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_X_CENTER = 3'd0,
    REG_X_SCALE  = 3'd1,
    REG_Y_CENTER = 3'd2,
    REG_Y_SCALE  = 3'd3,
    REG_VIEW     = 3'd4
  } reg_t;

  typedef enum logic [4:0] {
    STEP_P, STEP_Q, STEP_S, STEP_W, STEP_DEN1, STEP_DEN2, STEP_T1, STEP_T2,
    STEP_U1, STEP_U2, STEP_XP1, STEP_XP2, STEP_YP1, STEP_YP2,
    STEP_L1, STEP_L2, STEP_L3, STEP_L4
  } step_t;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_MUL, ST_DIV, ST_SX1, ST_SX2, ST_SY1, ST_SY2,
    ST_POS, ST_RD, ST_CMP, ST_DONE
  } state_t;

  typedef struct packed {
    logic              load;
    logic              mul_en;
    step_t             step;
    logic              div_en;
    logic              div_first;
    logic              scl_mul;
    logic              scl_inv;
    logic              scl_y;
    logic              pos;
    logic              mem_rd;
    logic              mem_cmp;
    logic              clr_we;
    logic [ADDR_W-1:0] clr_addr;
    logic              out_load;
  } ctl_t;

  typedef struct packed {
    logic den_pos;
    logic in_frame;
  } sts_t;

endpackage

// ----- rtl/core/tpz_ctrl.sv -----
`include "torus_point_zbuffer_plot_assert.svh"
module tpz_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  tpz_pkg::cmd_t in_cmd,
  output logic          in_ready,
  input  logic          out_ready,
  output logic          out_valid,
  output tpz_pkg::ctl_t ctl,
  input  tpz_pkg::sts_t sts
);

  tpz_pkg::state_t state, state_next;
  tpz_pkg::step_t  step, step_next;
  logic [tpz_pkg::CNT_W-1:0] cnt, cnt_next;
  logic clr_res, clr_res_next;

  // State, counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= tpz_pkg::ST_CLR;
      step    <= tpz_pkg::STEP_P;
      cnt     <= '0;
      clr_res <= 1'b0;
    end else begin
      state   <= state_next;
      step    <= step_next;
      cnt     <= cnt_next;
      clr_res <= clr_res_next;
    end
  end

  // Result word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    step_next    = step;
    cnt_next     = cnt;
    clr_res_next = clr_res;
    in_ready     = 1'b0;
    ctl          = '0;
    ctl.step     = step;
    ctl.clr_addr = cnt;
    case (state)
      tpz_pkg::ST_CLR: begin
        ctl.clr_we = 1'b1;
        if (cnt == tpz_pkg::CNT_W'(tpz_pkg::CELLS - 1)) begin
          state_next   = clr_res ? tpz_pkg::ST_DONE : tpz_pkg::ST_IDLE;
          clr_res_next = 1'b0;
          cnt_next     = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      tpz_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load = 1'b1;
          cnt_next = '0;
          case (in_cmd)
            tpz_pkg::CMD_CLEAR: begin
              state_next   = tpz_pkg::ST_CLR;
              clr_res_next = 1'b1;
            end
            tpz_pkg::CMD_PLOT: begin
              state_next = tpz_pkg::ST_MUL;
              step_next  = tpz_pkg::STEP_P;
            end
            tpz_pkg::CMD_READ: state_next = tpz_pkg::ST_RD;
            default:           state_next = tpz_pkg::ST_DONE;
          endcase
        end
      end
      tpz_pkg::ST_MUL: begin
        ctl.mul_en = 1'b1;
        if (step == tpz_pkg::STEP_L4) begin
          cnt_next   = '0;
          state_next = sts.den_pos ? tpz_pkg::ST_DIV : tpz_pkg::ST_DONE;
        end else begin
          step_next = tpz_pkg::step_t'(step + 1'b1);
        end
      end
      tpz_pkg::ST_DIV: begin
        ctl.div_en    = 1'b1;
        ctl.div_first = (cnt == '0);
        if (cnt == tpz_pkg::CNT_W'(tpz_pkg::DIV_STEPS - 1)) begin
          state_next = tpz_pkg::ST_SX1;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      tpz_pkg::ST_SX1: begin
        ctl.scl_mul = 1'b1;
        state_next  = tpz_pkg::ST_SX2;
      end
      tpz_pkg::ST_SX2: begin
        ctl.scl_inv = 1'b1;
        state_next  = tpz_pkg::ST_SY1;
      end
      tpz_pkg::ST_SY1: begin
        ctl.scl_mul = 1'b1;
        ctl.scl_y   = 1'b1;
        state_next  = tpz_pkg::ST_SY2;
      end
      tpz_pkg::ST_SY2: begin
        ctl.scl_inv = 1'b1;
        ctl.scl_y   = 1'b1;
        state_next  = tpz_pkg::ST_POS;
      end
      tpz_pkg::ST_POS: begin
        ctl.pos    = 1'b1;
        state_next = sts.in_frame ? tpz_pkg::ST_RD : tpz_pkg::ST_DONE;
      end
      tpz_pkg::ST_RD: begin
        ctl.mem_rd = 1'b1;
        state_next = tpz_pkg::ST_CMP;
      end
      tpz_pkg::ST_CMP: begin
        ctl.mem_cmp = 1'b1;
        state_next  = tpz_pkg::ST_DONE;
      end
      tpz_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          ctl.out_load = 1'b1;
          state_next   = tpz_pkg::ST_IDLE;
        end
      end
      default: state_next = tpz_pkg::ST_IDLE;
    endcase
  end

  `TPZ_ASSERT(a_plot_starts, (in_valid && in_ready && in_cmd == tpz_pkg::CMD_PLOT) |=> (state == tpz_pkg::ST_MUL && step == tpz_pkg::STEP_P))
  `TPZ_ASSERT(a_clr_bound, (state == tpz_pkg::ST_CLR) |-> (cnt < tpz_pkg::CNT_W'(tpz_pkg::CELLS)))
  `TPZ_ASSERT(a_div_bound, (state == tpz_pkg::ST_DIV) |-> (cnt < tpz_pkg::CNT_W'(tpz_pkg::DIV_STEPS)))
  `TPZ_ASSERT(a_result_from_done, $rose(out_valid) |-> ($past(state) == tpz_pkg::ST_DONE))
  `TPZ_ASSERT_ALWAYS(a_no_take_in_clear, (state == tpz_pkg::ST_CLR) |-> !in_ready)

endmodule

// ----- rtl/core/tpz_dp.sv -----
module tpz_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  tpz_pkg::ctl_t               ctl,
  output tpz_pkg::sts_t               sts,
  input  tpz_pkg::cmd_t               in_cmd,
  input  logic [143:0]                in_data,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [7:0]                  cfg_data,
  output logic [tpz_pkg::ADDR_W-1:0]  cell_addr,
  output logic [3:0]                  shade,
  output logic                        written
);

  localparam int TW = tpz_pkg::TMP_W;
  localparam int AW = tpz_pkg::ADDR_W;

  // Configuration registers
  logic [6:0] x_center;
  logic [7:0] x_scale;
  logic [4:0] y_center;
  logic [7:0] y_scale;
  logic [3:0] view_distance;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_center      <= 7'd40;
      x_scale       <= 8'd30;
      y_center      <= 5'd12;
      y_scale       <= 8'd15;
      view_distance <= 4'd5;
    end else if (cfg_we) begin
      case (tpz_pkg::reg_t'(cfg_index))
        tpz_pkg::REG_X_CENTER: x_center      <= cfg_data[6:0];
        tpz_pkg::REG_X_SCALE:  x_scale       <= cfg_data;
        tpz_pkg::REG_Y_CENTER: y_center      <= cfg_data[4:0];
        tpz_pkg::REG_Y_SCALE:  y_scale       <= cfg_data;
        tpz_pkg::REG_VIEW:     view_distance <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Input word capture
  tpz_pkg::cmd_t cmd_r;
  logic signed [15:0] si, ci, sj, cj, sa, ca, sb, cb;
  logic [AW-1:0] idx;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_cmd;
      si    <= in_data[15:0];
      ci    <= in_data[31:16];
      sj    <= in_data[47:32];
      cj    <= in_data[63:48];
      sa    <= in_data[79:64];
      ca    <= in_data[95:80];
      sb    <= in_data[111:96];
      cb    <= in_data[127:112];
      idx   <= in_data[138:128];
    end
  end

  function automatic logic signed [TW-1:0] ext_a(input logic signed [15:0] v);
    ext_a = {{(TW-16){v[15]}}, v};
  endfunction

  function automatic logic signed [16:0] ext_b(input logic signed [15:0] v);
    ext_b = {v[15], v};
  endfunction

  // Shared Q14 multiplier: operand select per step
  logic signed [16:0] c2;
  logic signed [TW-1:0] p, q, s, w, den, t, u, xp, yp, lum;
  logic signed [TW-1:0] a_op;
  logic signed [16:0]   b_op;
  logic signed [TW+16:0] mul_full;
  logic signed [TW-1:0] prod;

  assign c2 = {1'b0, ~cj[15], cj[14:0]};

  always_comb begin
    a_op = ext_a(si);
    b_op = c2;
    case (ctl.step)
      tpz_pkg::STEP_P:    begin a_op = ext_a(si); b_op = c2;        end
      tpz_pkg::STEP_Q:    begin a_op = ext_a(ci); b_op = c2;        end
      tpz_pkg::STEP_S:    begin a_op = ext_a(si); b_op = ext_b(cj); end
      tpz_pkg::STEP_W:    begin a_op = ext_a(ci); b_op = ext_b(cj); end
      tpz_pkg::STEP_DEN1: begin a_op = p;         b_op = ext_b(sa); end
      tpz_pkg::STEP_DEN2: begin a_op = ext_a(sj); b_op = ext_b(ca); end
      tpz_pkg::STEP_T1:   begin a_op = p;         b_op = ext_b(ca); end
      tpz_pkg::STEP_T2:   begin a_op = ext_a(sj); b_op = ext_b(sa); end
      tpz_pkg::STEP_U1:   begin a_op = ext_a(sj); b_op = ext_b(sa); end
      tpz_pkg::STEP_U2:   begin a_op = s;         b_op = ext_b(ca); end
      tpz_pkg::STEP_XP1:  begin a_op = q;         b_op = ext_b(cb); end
      tpz_pkg::STEP_XP2:  begin a_op = t;         b_op = ext_b(sb); end
      tpz_pkg::STEP_YP1:  begin a_op = q;         b_op = ext_b(sb); end
      tpz_pkg::STEP_YP2:  begin a_op = t;         b_op = ext_b(cb); end
      tpz_pkg::STEP_L1:   begin a_op = u;         b_op = ext_b(cb); end
      tpz_pkg::STEP_L2:   begin a_op = s;         b_op = ext_b(sa); end
      tpz_pkg::STEP_L3:   begin a_op = ext_a(sj); b_op = ext_b(ca); end
      tpz_pkg::STEP_L4:   begin a_op = w;         b_op = ext_b(sb); end
      default: ;
    endcase
  end

  // Arithmetic shift floors the Q14 product
  assign mul_full = a_op * b_op;
  assign prod     = mul_full[TW+13:14];

  // Accumulate into the step's destination
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      case (ctl.step)
        tpz_pkg::STEP_P:    p   <= prod;
        tpz_pkg::STEP_Q:    q   <= prod;
        tpz_pkg::STEP_S:    s   <= prod;
        tpz_pkg::STEP_W:    w   <= prod;
        tpz_pkg::STEP_DEN1: den <= prod + {7'd0, view_distance, 14'd0};
        tpz_pkg::STEP_DEN2: den <= den + prod;
        tpz_pkg::STEP_T1:   t   <= prod;
        tpz_pkg::STEP_T2:   t   <= t - prod;
        tpz_pkg::STEP_U1:   u   <= prod;
        tpz_pkg::STEP_U2:   u   <= u - prod;
        tpz_pkg::STEP_XP1:  xp  <= prod;
        tpz_pkg::STEP_XP2:  xp  <= xp - prod;
        tpz_pkg::STEP_YP1:  yp  <= prod;
        tpz_pkg::STEP_YP2:  yp  <= yp + prod;
        tpz_pkg::STEP_L1:   lum <= prod;
        tpz_pkg::STEP_L2:   lum <= lum - prod;
        tpz_pkg::STEP_L3:   lum <= lum - prod;
        tpz_pkg::STEP_L4:   lum <= lum - prod;
        default: ;
      endcase
    end
  end

  assign sts.den_pos = !den[TW-1] && (den != '0);

  // Restoring divider for 2^30 / den, one quotient bit a cycle
  logic [tpz_pkg::REM_W-2:0] rem;
  logic [tpz_pkg::REM_W-1:0] trial;
  logic [tpz_pkg::REM_W-1:0] diff;
  logic [tpz_pkg::DIV_STEPS-1:0] quot;
  logic [15:0] inv;
  logic trial_ge;

  assign trial    = ctl.div_first ? tpz_pkg::REM_W'(1) : {rem, 1'b0};
  assign trial_ge = trial >= den[tpz_pkg::REM_W-1:0];
  assign diff     = trial - den[tpz_pkg::REM_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.div_en) begin
      rem  <= trial_ge ? diff[tpz_pkg::REM_W-2:0] : trial[tpz_pkg::REM_W-2:0];
      quot <= ctl.div_first ? tpz_pkg::DIV_STEPS'(trial_ge)
                            : {quot[tpz_pkg::DIV_STEPS-2:0], trial_ge};
    end
  end

  assign inv = (quot[tpz_pkg::DIV_STEPS-1:16] != '0) ? 16'hFFFF : quot[15:0];

  // Screen projection: scale, then inverse depth
  logic signed [TW+8:0]  mx;
  logic signed [TW+25:0] px, py, scl_prod;

  assign scl_prod = mx * $signed({1'b0, inv});

  always_ff @(posedge clk) begin
    if (ctl.scl_mul) begin
      mx <= ctl.scl_y ? yp * $signed({1'b0, y_scale}) : xp * $signed({1'b0, x_scale});
    end
    if (ctl.scl_inv) begin
      if (ctl.scl_y) begin
        py <= scl_prod;
      end else begin
        px <= scl_prod;
      end
    end
  end

  // Add center, truncate toward zero, range check
  logic signed [TW+26:0] sum_x, sum_y, adj_x, adj_y;
  logic signed [21:0] x_pos, y_pos;
  logic inside_now;
  logic [AW-1:0] o_now, o_reg;
  logic inside_reg;

  assign sum_x = {px[TW+25], px} + {15'd0, x_center, 30'd0};
  assign sum_y = {py[TW+25], py} + {17'd0, y_center, 30'd0};
  assign adj_x = sum_x[TW+26] ? sum_x + 52'sd1073741823 : sum_x;
  assign adj_y = sum_y[TW+26] ? sum_y + 52'sd1073741823 : sum_y;
  assign x_pos = adj_x[TW+26:30];
  assign y_pos = adj_y[TW+26:30];
  assign inside_now = (x_pos > 22'sd0) && (x_pos < 22'(tpz_pkg::COLS))
                   && (y_pos > 22'sd0) && (y_pos < 22'(tpz_pkg::ROWS));
  assign o_now = AW'(x_pos[tpz_pkg::X_W-1:0])
               + AW'(tpz_pkg::COLS) * AW'(y_pos[tpz_pkg::Y_W-1:0]);
  assign sts.in_frame = inside_now;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      inside_reg <= 1'b0;
    end else if (ctl.pos) begin
      inside_reg <= inside_now;
      o_reg      <= o_now;
    end
  end

  // Frame stores
  logic [15:0] depth_mem [0:tpz_pkg::CELLS-1];
  logic [3:0]  shade_mem [0:tpz_pkg::CELLS-1];
  logic [15:0] depth_q;
  logic [3:0]  shade_q;
  logic        idx_ok, plot_wr, mem_we, wr_flag;
  logic [AW-1:0] wa, ra;
  logic [3:0]  shade_calc;

  assign idx_ok  = idx < AW'(tpz_pkg::CELLS);
  assign ra      = (cmd_r == tpz_pkg::CMD_READ) ? (idx_ok ? idx : '0) : o_reg;
  assign plot_wr = ctl.mem_cmp && (cmd_r == tpz_pkg::CMD_PLOT) && (inv > depth_q);
  assign mem_we  = ctl.clr_we || plot_wr;
  assign wa      = ctl.clr_we ? ctl.clr_addr : o_reg;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      depth_mem[wa] <= ctl.clr_we ? 16'd0 : inv;
      shade_mem[wa] <= ctl.clr_we ? tpz_pkg::BLANK : shade_calc;
    end
    if (ctl.mem_rd) begin
      depth_q <= depth_mem[ra];
      shade_q <= shade_mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      wr_flag <= 1'b0;
    end else if (plot_wr) begin
      wr_flag <= 1'b1;
    end
  end

  // Luminance clamp: trunc(lum / 2048) into 0..11
  always_comb begin
    if (lum < TW'(2048)) begin
      shade_calc = 4'd0;
    end else if (lum >= TW'(24576)) begin
      shade_calc = 4'd11;
    end else begin
      shade_calc = lum[14:11];
    end
  end

  // Result word register
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      case (cmd_r)
        tpz_pkg::CMD_CLEAR: begin
          cell_addr <= '0;
          shade     <= tpz_pkg::BLANK;
          written   <= 1'b0;
        end
        tpz_pkg::CMD_PLOT: begin
          cell_addr <= inside_reg ? o_reg : '0;
          shade     <= shade_calc;
          written   <= wr_flag;
        end
        tpz_pkg::CMD_READ: begin
          cell_addr <= idx;
          shade     <= idx_ok ? shade_q : tpz_pkg::BLANK;
          written   <= 1'b0;
        end
        default: begin
          cell_addr <= '0;
          shade     <= 4'd0;
          written   <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/torus_point_zbuffer_plot.sv -----
// Channel  Signals                   Contents
// s_axis   tvalid tready tdata tuser  command word in, fields below
// m_axis   tvalid tready tdata        result word out
// cfg      cfg_we cfg_index cfg_data  register writes, no read-back
//
// Plot: 18 steps on one shared Q14 multiplier and a bit-serial reciprocal;
// an off-frame point skips the store access, a non-positive depth all after the multiplier.
// Clear: one cell a cycle through both stores.
// After reset the same clearing pass runs with s_axis_tready low.
// A result word waits in the output register while the next word is taken.
module torus_point_zbuffer_plot (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // sin_i, cos_i, sin_j, cos_j, sin_a, cos_a, sin_b, cos_b, cell_index, zero pad
  input  logic [143:0] s_axis_tdata,
  // command
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // cell_addr, shade, written
  output logic [15:0]  m_axis_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [7:0]   cfg_data
);

  tpz_pkg::ctl_t ctl;
  tpz_pkg::sts_t sts;
  tpz_pkg::cmd_t in_cmd;
  logic [tpz_pkg::ADDR_W-1:0] cell_addr;
  logic [3:0] shade;
  logic written;

  assign in_cmd       = tpz_pkg::cmd_t'(s_axis_tuser);
  assign m_axis_tdata = {written, shade, cell_addr};

  tpz_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_cmd    (in_cmd),
    .in_ready  (s_axis_tready),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .ctl       (ctl),
    .sts       (sts)
  );

  tpz_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sts       (sts),
    .in_cmd    (in_cmd),
    .in_data   (s_axis_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cell_addr (cell_addr),
    .shade     (shade),
    .written   (written)
  );

endmodule

// ----- tb/sv/tb_torus_point_zbuffer_plot.sv -----
`timescale 1ns / 100ps

module tb_torus_point_zbuffer_plot;

  localparam int WATCH_LIMIT = 40000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = tpz_pkg::CMD_NOP;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [15:0]  m_axis_tdata;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = tpz_pkg::REG_X_CENTER;
  logic [7:0]   cfg_data = '0;

  typedef struct {
    logic [10:0] addr;
    logic [3:0]  shade;
    logic        wr;
  } cell_word_t;

  typedef struct {
    tpz_pkg::cmd_t cmd;
    logic [127:0]  ang;
    logic [10:0]   idx;
    bit            typed;
    cell_word_t    res;
  } stim_row_t;

  // shadow of the frame and the registers
  logic [15:0] depth_mem [tpz_pkg::CELLS];
  logic [3:0]  shade_mem [tpz_pkg::CELLS];
  longint      xc_q, xs_q, yc_q, ys_q, vd_q;

  cell_word_t  pending_words[$];
  cell_word_t  typed_res;
  bit          typed_on;
  int          n_bad;
  int          idle_cyc;
  int          s_idle_pct, r_idle_pct;
  logic [10:0] last_cell;

  torus_point_zbuffer_plot dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint qm(longint a, longint b);
    return (a * b) >>> 14;
  endfunction

  function automatic longint sx(logic [15:0] v);
    return longint'(signed'(v));
  endfunction

  // compute the result word of one command and update the shadow frame
  function automatic cell_word_t frame_step(tpz_pkg::cmd_t c, logic [127:0] ang,
                                            logic [10:0] ix);
    cell_word_t r;
    longint si, ci, sj, cj, sa, ca, sb, cb;
    longint c2, p, den, t, q, xp, yp, s, u, lum, n, inv, x, y, o;
    r = '{addr: '0, shade: '0, wr: 1'b0};
    case (c)
      tpz_pkg::CMD_CLEAR: begin
        for (int k = 0; k < tpz_pkg::CELLS; k++) begin
          depth_mem[k] = '0;
          shade_mem[k] = tpz_pkg::BLANK;
        end
        r.shade = tpz_pkg::BLANK;
      end
      tpz_pkg::CMD_PLOT: begin
        si = sx(ang[15:0]);   ci = sx(ang[31:16]);
        sj = sx(ang[47:32]);  cj = sx(ang[63:48]);
        sa = sx(ang[79:64]);  ca = sx(ang[95:80]);
        sb = sx(ang[111:96]); cb = sx(ang[127:112]);
        c2  = cj + 32768;
        p   = qm(si, c2);
        den = qm(p, sa) + qm(sj, ca) + vd_q * 16384;
        t   = qm(p, ca) - qm(sj, sa);
        q   = qm(ci, c2);
        xp  = qm(q, cb) - qm(t, sb);
        yp  = qm(q, sb) + qm(t, cb);
        s   = qm(si, cj);
        u   = qm(sj, sa) - qm(s, ca);
        lum = qm(u, cb) - qm(s, sa) - qm(sj, ca) - qm(qm(ci, cj), sb);
        n   = lum / 2048;
        r.shade = (n <= 0) ? 4'd0 : (n > 11) ? 4'd11 : 4'(n);
        if (den > 0) begin
          inv = (longint'(1) << 30) / den;
          if (inv > 65535) inv = 65535;
          x = (xc_q * (longint'(1) << 30) + xs_q * inv * xp) / (longint'(1) << 30);
          y = (yc_q * (longint'(1) << 30) + ys_q * inv * yp) / (longint'(1) << 30);
          if (x > 0 && x < tpz_pkg::COLS && y > 0 && y < tpz_pkg::ROWS) begin
            o = x + tpz_pkg::COLS * y;
            r.addr = 11'(o);
            if (inv > longint'(depth_mem[o])) begin
              depth_mem[o] = 16'(inv);
              shade_mem[o] = r.shade;
              r.wr = 1'b1;
            end
          end
        end
      end
      tpz_pkg::CMD_READ: begin
        r.addr  = ix;
        r.shade = (ix < tpz_pkg::CELLS) ? shade_mem[ix] : tpz_pkg::BLANK;
      end
      default: ;
    endcase
    return r;
  endfunction

  // input side: predict on every accepted word
  always @(posedge clk) begin
    cell_word_t r;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      r = frame_step(tpz_pkg::cmd_t'(s_axis_tuser), s_axis_tdata[127:0],
                     s_axis_tdata[138:128]);
      if (r.addr != 0) last_cell = r.addr;
      pending_words.push_back(typed_on ? typed_res : r);
    end
  end

  // output side: compare against the oldest prediction
  always @(posedge clk) begin
    cell_word_t w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word, actual %h", $time, m_axis_tdata);
        n_bad++;
      end else begin
        w = pending_words.pop_front();
        if (m_axis_tdata[10:0] != w.addr || m_axis_tdata[14:11] != w.shade ||
            m_axis_tdata[15] != w.wr) begin
          $display("%0t: mismatch, expected addr %0d shade %0d wr %0d, actual addr %0d shade %0d wr %0d",
                   $time, w.addr, w.shade, w.wr,
                   m_axis_tdata[10:0], m_axis_tdata[14:11], m_axis_tdata[15]);
          n_bad++;
        end
      end
    end
  end

  // watchdog on stalled traffic
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cyc = 0;
    else idle_cyc++;
    if (idle_cyc > WATCH_LIMIT) begin
      $display("tb_torus_point_zbuffer_plot: done, errors");
      $finish;
    end
  end

  // random backpressure on the result side
  always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= r_idle_pct);

  task automatic set_regs(int xc, int xs, int yc, int ys, int vd);
    int v [5];
    v = '{xc, xs, yc, ys, vd};
    for (int k = 0; k < 5; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= tpz_pkg::reg_t'(k);
      cfg_data  <= 8'(v[k]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    xc_q = xc; xs_q = xs; yc_q = yc; ys_q = ys; vd_q = vd;
  endtask

  // hold off until every result word has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_words.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // present one word, starting and returning at a falling edge
  task automatic send_word(tpz_pkg::cmd_t c, logic [127:0] ang, logic [10:0] ix);
    while ($urandom_range(99) < s_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tdata  <= {5'b0, ix, ang};
    s_axis_tuser  <= c;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  function automatic logic [15:0] to_q14(real v);
    return 16'($rtoi(v * 16384.0 + ((v < 0.0) ? -0.5 : 0.5)));
  endfunction

  function automatic logic [127:0] torus_angles();
    logic [127:0] a;
    real th;
    for (int k = 0; k < 4; k++) begin
      th = $urandom_range(0, 62831) / 10000.0;
      a[32*k +: 16]      = to_q14($sin(th));
      a[32*k + 16 +: 16] = to_q14($cos(th));
    end
    return a;
  endfunction

  function automatic logic [127:0] all_lanes(logic [15:0] v);
    return {8{v}};
  endfunction

  task automatic random_phase(int count, bit hold_mid);
    int r;
    logic [10:0] ix;
    for (int k = 0; k < count; k++) begin
      if (hold_mid && k == count / 2) drain();
      r  = $urandom_range(99);
      ix = ($urandom_range(3) == 0) ? last_cell : 11'($urandom_range(2047));
      if (r < 1)       send_word(tpz_pkg::CMD_CLEAR, '0, '0);
      else if (r < 4)  send_word(tpz_pkg::CMD_NOP, {$urandom, $urandom, $urandom, $urandom},
                                 11'($urandom));
      else if (r < 18) send_word(tpz_pkg::CMD_READ, '0, ix);
      else if (r < 88) send_word(tpz_pkg::CMD_PLOT, torus_angles(), 11'($urandom));
      else             send_word(tpz_pkg::CMD_PLOT, {$urandom, $urandom, $urandom, $urandom},
                                 11'($urandom));
    end
    drain();
  endtask

  stim_row_t rows [$];

  initial begin
    n_bad = 0; idle_cyc = 0; typed_on = 1'b0; last_cell = '0;
    s_idle_pct = 0; r_idle_pct = 0;
    xc_q = 40; xs_q = 30; yc_q = 12; ys_q = 15; vd_q = 5;
    for (int k = 0; k < tpz_pkg::CELLS; k++) begin
      depth_mem[k] = '0;
      shade_mem[k] = tpz_pkg::BLANK;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    set_regs(40, 30, 12, 15, 5);

    // directed: reset contents, extremes, every command, depth test
    rows = '{
      '{tpz_pkg::CMD_READ,  '0, 11'd0,    1, '{11'd0,    tpz_pkg::BLANK, 1'b0}},
      '{tpz_pkg::CMD_READ,  '0, 11'd1759, 1, '{11'd1759, tpz_pkg::BLANK, 1'b0}},
      '{tpz_pkg::CMD_READ,  '0, 11'd2047, 1, '{11'd2047, tpz_pkg::BLANK, 1'b0}},
      '{tpz_pkg::CMD_NOP,   '1, 11'h7ff,  1, '{11'd0,    4'd0,  1'b0}},
      '{tpz_pkg::CMD_CLEAR, '1, 11'h7ff,  1, '{11'd0,    tpz_pkg::BLANK, 1'b0}},
      '{tpz_pkg::CMD_PLOT,  {16'd16384, 16'd0, 16'd16384, 16'd0, 16'd16384, 16'd0,
                             16'd16384, 16'd0}, 11'd0, 0, '{'0, '0, 1'b0}},
      '{tpz_pkg::CMD_PLOT,  {16'd16384, 16'd0, 16'd16384, 16'd0, 16'd16384, 16'd0,
                             16'd16384, 16'd0}, 11'd0, 0, '{'0, '0, 1'b0}},
      '{tpz_pkg::CMD_READ,  '0, 11'd1012, 0, '{'0, '0, 1'b0}},
      '{tpz_pkg::CMD_PLOT,  all_lanes(16'hc000), 11'd0, 0, '{'0, '0, 1'b0}},
      '{tpz_pkg::CMD_PLOT,  all_lanes(16'h4000), 11'd0, 0, '{'0, '0, 1'b0}},
      '{tpz_pkg::CMD_PLOT,  all_lanes(16'h8000), 11'd0, 0, '{'0, '0, 1'b0}},
      '{tpz_pkg::CMD_PLOT,  all_lanes(16'h7fff), 11'd0, 0, '{'0, '0, 1'b0}},
      '{tpz_pkg::CMD_PLOT,  {16'd11585, 16'hd2bf, 16'd16384, 16'd0, 16'd0, 16'hc000,
                             16'd11585, 16'd11585}, 11'd0, 0, '{'0, '0, 1'b0}},
      '{tpz_pkg::CMD_PLOT,  {16'h0000, 16'hc000, 16'd11585, 16'd11585, 16'd16384, 16'd0,
                             16'hd2bf, 16'd11585}, 11'd0, 0, '{'0, '0, 1'b0}},
      '{tpz_pkg::CMD_CLEAR, '0, 11'd0,    1, '{11'd0,    tpz_pkg::BLANK, 1'b0}},
      '{tpz_pkg::CMD_READ,  '0, 11'd1012, 1, '{11'd1012, tpz_pkg::BLANK, 1'b0}}
    };
    foreach (rows[k]) begin
      typed_on  = rows[k].typed;
      typed_res = rows[k].res;
      send_word(rows[k].cmd, rows[k].ang, rows[k].idx);
    end
    typed_on = 1'b0;
    drain();

    // wide scales, far view: many points off frame
    set_regs(79, 255, 21, 255, 15);
    s_idle_pct = 34; r_idle_pct = 65;
    random_phase(300, 0);

    // zero scales and centers: everything collapses off frame
    set_regs(0, 0, 0, 0, 4);
    random_phase(60, 0);

    // near view, moderate scales
    set_regs(40, 60, 11, 30, 4);
    s_idle_pct = 65; r_idle_pct = 34;
    random_phase(700, 1);

    // back to the usual view, no idling
    set_regs(40, 30, 12, 15, 5);
    s_idle_pct = 0; r_idle_pct = 0;
    random_phase(740, 0);

    repeat (100) @(posedge clk);
    if (n_bad == 0 && pending_words.size() == 0) begin
      $display("tb_torus_point_zbuffer_plot: done, clean");
    end else begin
      $display("tb_torus_point_zbuffer_plot: done, errors");
    end
    $finish;
  end

endmodule
